>>> rtl/core/sfr_pkg.sv
// shared types, constants and register indexes of the stuffed frame receiver
package sfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE  = 3'd6;

    localparam logic [BYTE_W-1:0] FLAG_RST      = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RST    = 8'd125;
    localparam logic [BYTE_W-1:0] MASK_RST      = 8'd32;
    localparam logic [BYTE_W-1:0] SENDER_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] RECEIVER_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] CTRL_ZERO_RST = 8'd0;
    localparam logic [BYTE_W-1:0] CTRL_ONE_RST  = 8'd64;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] sender_address;
        logic [BYTE_W-1:0] receiver_address;
        logic [BYTE_W-1:0] control_seq_zero;
        logic [BYTE_W-1:0] control_seq_one;
    } cfg_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_good;
        logic              frame_sequence;
        logic              reply_is_reject;
        logic              reply_sequence;
        logic              frame_last;
    } result_t;

    typedef struct packed {
        logic    push_one;
        logic    push_two;
        result_t first;
        result_t second;
    } push_t;

endpackage

>>> rtl/core/sfr_front.sv
// front end: frame hunt, unstuffing and verdict, up to two results per byte
module sfr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfr_pkg::cfg_t                cfg,
    input  logic                         take,
    input  logic [sfr_pkg::BYTE_W-1:0]   line_byte,
    output sfr_pkg::push_t               push
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_HCHK = 3'd3,
        PH_BODY = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic              seq_reg, seq_next;
    logic              esc_reg, esc_next;
    logic              hv_reg, hv_next;
    logic [BYTE_W-1:0] hb_reg, hb_next;
    logic [BYTE_W-1:0] par_reg, par_next;

    logic              p1_en, p2_en, verdict, clear;
    logic [BYTE_W-1:0] p1_val, p2_val, ctrl_byte;
    logic [1:0]        n;
    logic              good;
    result_t           r0, r1, pay;

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        seq_next   = seq_reg;
        esc_next   = esc_reg;
        p1_en      = 1'b0;
        p2_en      = 1'b0;
        p1_val     = line_byte;
        p2_val     = line_byte;
        verdict    = 1'b0;
        clear      = 1'b0;
        ctrl_byte  = seq_reg ? cfg.control_seq_one : cfg.control_seq_zero;

        unique case (phase_reg)
            PH_ADDR:
            begin
                if (line_byte == cfg.sender_address || line_byte == cfg.receiver_address)
                begin
                    addr_next  = line_byte;
                    phase_next = PH_CTRL;
                end
                else if (line_byte != cfg.flag_value)
                begin
                    clear      = 1'b1;
                    phase_next = PH_HUNT;
                end
            end
            PH_CTRL:
            begin
                if (line_byte == cfg.control_seq_zero || line_byte == cfg.control_seq_one)
                begin
                    seq_next   = (line_byte != cfg.control_seq_zero);
                    phase_next = PH_HCHK;
                end
                else
                begin
                    clear      = 1'b1;
                    phase_next = (line_byte == cfg.flag_value) ? PH_ADDR : PH_HUNT;
                end
            end
            PH_HCHK:
            begin
                if (line_byte == (addr_reg ^ ctrl_byte))
                begin
                    esc_next   = 1'b0;
                    phase_next = PH_BODY;
                end
                else
                begin
                    clear      = 1'b1;
                    phase_next = (line_byte == cfg.flag_value) ? PH_ADDR : PH_HUNT;
                end
            end
            PH_BODY:
            begin
                if (line_byte == cfg.flag_value)
                begin
                    p1_en      = esc_reg;
                    p1_val     = cfg.escape_value;
                    verdict    = 1'b1;
                    clear      = 1'b1;
                    phase_next = PH_HUNT;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    p1_en    = 1'b1;
                    if (line_byte == (cfg.flag_value ^ cfg.stuff_mask))
                        p1_val = cfg.flag_value;
                    else if (line_byte == (cfg.escape_value ^ cfg.stuff_mask))
                        p1_val = cfg.escape_value;
                    else
                    begin
                        p1_val = cfg.escape_value;
                        if (line_byte == cfg.escape_value)
                            esc_next = 1'b1;
                        else
                            p2_en = 1'b1;
                    end
                end
                else if (line_byte == cfg.escape_value)
                    esc_next = 1'b1;
                else
                    p1_en = 1'b1;
            end
            default:
            begin
                clear      = 1'b1;
                phase_next = (line_byte == cfg.flag_value) ? PH_ADDR : PH_HUNT;
            end
        endcase

        // unstuffed bytes shift through the one-byte hold
        n        = 2'd0;
        hv_next  = (phase_reg == PH_BODY) ? hv_reg : 1'b0;
        hb_next  = (phase_reg == PH_BODY) ? hb_reg : '0;
        par_next = (phase_reg == PH_BODY) ? par_reg : '0;
        pay      = '0;
        pay.result_kind    = KIND_PAYLOAD;
        pay.frame_sequence = seq_reg;
        r0 = pay;
        r1 = pay;

        if (p1_en)
        begin
            if (hv_next)
            begin
                r0.payload_byte = hb_next;
                par_next = par_next ^ hb_next;
                n = 2'd1;
            end
            hb_next = p1_val;
            hv_next = 1'b1;
        end
        if (p2_en)
        begin
            if (n == 2'd0)
                r0.payload_byte = hb_next;
            else
                r1.payload_byte = hb_next;
            par_next = par_next ^ hb_next;
            n = n + 2'd1;
            hb_next = p2_val;
        end

        good = hv_next && (hb_next == par_next);
        if (verdict)
        begin
            if (n == 2'd0)
            begin
                r0.result_kind     = KIND_VERDICT;
                r0.frame_good      = good;
                r0.reply_is_reject = !good;
                r0.reply_sequence  = good ? !seq_reg : seq_reg;
                r0.frame_last      = 1'b1;
            end
            else
            begin
                r1.result_kind     = KIND_VERDICT;
                r1.frame_good      = good;
                r1.reply_is_reject = !good;
                r1.reply_sequence  = good ? !seq_reg : seq_reg;
                r1.frame_last      = 1'b1;
            end
            n = n + 2'd1;
        end

        if (clear)
        begin
            addr_next = '0;
            seq_next  = 1'b0;
            esc_next  = 1'b0;
            hv_next   = 1'b0;
            hb_next   = '0;
            par_next  = '0;
        end

        push.push_one = take && (n != 2'd0);
        push.push_two = take && (n == 2'd2);
        push.first    = r0;
        push.second   = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            addr_reg  <= '0;
            seq_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            hv_reg    <= 1'b0;
            hb_reg    <= '0;
            par_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            seq_reg   <= seq_next;
            esc_reg   <= esc_next;
            hv_reg    <= hv_next;
            hb_reg    <= hb_next;
            par_reg   <= par_next;
        end
    end

endmodule

>>> rtl/core/sfr_back.sv
// back end: small result queue with two write slots and a registered output stage
module sfr_back #(
    parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sfr_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output sfr_pkg::result_t out_item
);
    import sfr_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next, tail_plus;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               valid_reg, valid_next;
    result_t            item_reg;
    logic               pop;

    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = (count_reg != '0) && (!valid_reg || out_ready);
    assign tail_plus = tail_reg + PTR_W'(1);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.push_one) + PTR_W'(push.push_two);
        count_next = count_reg + CNT_W'(push.push_one) + CNT_W'(push.push_two)
                     - CNT_W'(pop);
        valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_one)
            entry_reg[tail_reg] <= push.first;
        if (push.push_two)
            entry_reg[tail_plus] <= push.second;
        if (pop)
            item_reg <= entry_reg[head_reg];
    end

endmodule

>>> rtl/core/stuffed_frame_receiver.sv
// top level of the byte-stuffed frame receiver
//
// line bytes enter on the s_axis channel, one item per cycle when ready; results
// leave on the m_axis channel. a result is either a payload byte (tuser low) or an end
// of frame verdict (tuser high, tlast high) carrying the check outcome and the
// reply kind with its sequence. body bytes come out one byte late, since the
// last body byte is held back as the frame check.
// one line byte can give two results (a stuffed escape resolved together with
// the held byte, or the last payload byte and the verdict at the closing flag).
// the front parser takes one byte per cycle while s_axis_tready is high and writes
// its results into a four-entry queue; the back end drains one result per cycle
// into an output register while that register is empty or m_axis_tready is high.
// s_axis_tready drops while the queue has fewer than two free entries, so a
// stalled m_axis side backs up into the line side after the queue fills; bytes
// that give two results can only be sustained at the output rate of one a cycle.
// reset clears the parser to the flag hunt, empties the queue and loads the
// configuration registers with their defaults. the user must write configuration
// through cfg_we/cfg_addr/cfg_wdata only while the block is idle; it is not enforced.
module stuffed_frame_receiver #(
    parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [sfr_pkg::BYTE_W-1:0]       cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]       s_axis_tdata,  // line_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // payload_byte, frame_good, frame_sequence, reply_is_reject, reply_sequence, zero fill
    output logic [sfr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser,  // result_kind
    output logic                             m_axis_tlast   // frame_last
);
    import sfr_pkg::*;

    cfg_t    cfg_reg;
    push_t   push;
    result_t item;
    logic    take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value       <= FLAG_RST;
            cfg_reg.escape_value     <= ESCAPE_RST;
            cfg_reg.stuff_mask       <= MASK_RST;
            cfg_reg.sender_address   <= SENDER_RST;
            cfg_reg.receiver_address <= RECEIVER_RST;
            cfg_reg.control_seq_zero <= CTRL_ZERO_RST;
            cfg_reg.control_seq_one  <= CTRL_ONE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FLAG:      cfg_reg.flag_value       <= cfg_wdata;
                CFG_ESCAPE:    cfg_reg.escape_value     <= cfg_wdata;
                CFG_MASK:      cfg_reg.stuff_mask       <= cfg_wdata;
                CFG_SENDER:    cfg_reg.sender_address   <= cfg_wdata;
                CFG_RECEIVER:  cfg_reg.receiver_address <= cfg_wdata;
                CFG_CTRL_ZERO: cfg_reg.control_seq_zero <= cfg_wdata;
                CFG_CTRL_ONE:  cfg_reg.control_seq_one  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign take = s_axis_tvalid && s_axis_tready;

    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .line_byte (s_axis_tdata),
        .push      (push)
    );

    sfr_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (item)
    );

    assign m_axis_tdata = {4'b0000, item.reply_sequence, item.reply_is_reject,
                           item.frame_sequence, item.frame_good, item.payload_byte};
    assign m_axis_tuser = item.result_kind;
    assign m_axis_tlast = item.frame_last;

endmodule
